@@ hdl/linear_adsr_envelope_macros.svh @@
// Assertion helpers shared by the envelope modules.
// Both expect clk_i and rst_ni in scope.
`ifndef LINEAR_ADSR_ENVELOPE_MACROS_SVH
`define LINEAR_ADSR_ENVELOPE_MACROS_SVH

// same-cycle implication
`define LAE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LAE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lae_pkg.sv @@
`default_nettype none

package lae_pkg;

  localparam int SampleW  = 24;
  localparam int LevelW   = 24;
  localparam int FracBits = 23;
  localparam int ProdW    = SampleW + LevelW + 1;
  localparam int ShiftW   = ProdW - FracBits;

  localparam logic [LevelW-1:0] One         = LevelW'(1) << FracBits;
  localparam logic [LevelW-1:0] FinishLimit = LevelW'(8389);

  localparam logic [LevelW-1:0] AttackStepRst   = LevelW'(8388);
  localparam logic [LevelW-1:0] DecayStepRst    = LevelW'(8388);
  localparam logic [LevelW-1:0] SustainLevelRst = One;
  localparam logic [LevelW-1:0] ReleaseStepRst  = LevelW'(8388);

  // queue sizes, powers of two so pointers wrap on their own
  localparam int CmdQDepth = 4;
  localparam int CmdPtrW   = 2;
  localparam int ResQDepth = 4;
  localparam int ResPtrW   = 2;
  localparam int CntW      = 3;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_ATTACK  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_e;

  typedef enum logic [1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_DECAY   = 2'd1,
    CFG_SUSTAIN = 2'd2,
    CFG_RELEASE = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_ATTACK  = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [LevelW-1:0] attack_step;
    logic [LevelW-1:0] decay_step;
    logic [LevelW-1:0] sustain_level;
    logic [LevelW-1:0] release_step;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [SampleW-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic [SampleW-1:0] out_sample;
    logic [LevelW-1:0]  level;
    stage_e             stage;
    logic               active;
    logic               finished;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/lae_front.sv @@
`default_nettype none

module lae_front (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         push_i,
  output logic                        full_o,
  input  wire  [1:0]                  operation_i,
  input  wire  [lae_pkg::SampleW-1:0] in_sample_i,
  output logic                        cmd_valid_o,
  output lae_pkg::cmd_t               cmd_o,
  input  wire                         cmd_pop_i
);

  `include "linear_adsr_envelope_macros.svh"

  lae_pkg::cmd_t                 mem_q [lae_pkg::CmdQDepth];
  logic [lae_pkg::CmdPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [lae_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic                          accept, enq, deq;
  lae_pkg::cmd_t                 cmd_new;

  assign full_o      = (cnt_q == lae_pkg::CntW'(lae_pkg::CmdQDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign accept      = push_i && !full_o;
  assign deq         = cmd_pop_i && cmd_valid_o;

  // classify; the unused opcode is dropped here
  always_comb begin
    cmd_new.sample = in_sample_i;
    cmd_new.kind   = lae_pkg::CMD_SAMPLE;
    enq            = accept;
    case (lae_pkg::op_e'(operation_i))
      lae_pkg::OP_SAMPLE:  cmd_new.kind = lae_pkg::CMD_SAMPLE;
      lae_pkg::OP_ATTACK:  cmd_new.kind = lae_pkg::CMD_ATTACK;
      lae_pkg::OP_RELEASE: cmd_new.kind = lae_pkg::CMD_RELEASE;
      default:             enq = 1'b0;
    endcase
  end

  always_comb begin
    case ({enq, deq})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (enq) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (deq) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) mem_q[wr_ptr_q] <= cmd_new;
  end

  `LAE_ASSERT_NXT(a_drop_unused, accept && (operation_i == lae_pkg::OP_NONE) && !deq,
                  $stable(cnt_q), "unused opcode entered the command queue")

endmodule

`default_nettype wire

@@ hdl/lae_back.sv @@
`default_nettype none

module lae_back (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  lae_pkg::cfg_t             cfg_i,
  input  wire                       cmd_valid_i,
  input  lae_pkg::cmd_t             cmd_i,
  output logic                      cmd_pop_o,
  input  wire  [lae_pkg::CntW-1:0]  res_cnt_i,
  output logic                      res_push_o,
  output lae_pkg::res_t             res_o
);

  `include "linear_adsr_envelope_macros.svh"

  localparam int AccW = lae_pkg::LevelW + 2;

  lae_pkg::stage_e                    stage_q, stage_d;
  logic [lae_pkg::LevelW-1:0]         level_q, level_d;
  logic [lae_pkg::LevelW-1:0]         sus;
  logic [AccW-1:0]                    att_sum, dec_dif, rel_dif;
  logic [lae_pkg::CntW-1:0]           busy;
  logic                               issue, is_sample;

  logic                               s1_valid_q;
  logic signed [lae_pkg::SampleW-1:0] s1_sample_q;
  logic [lae_pkg::LevelW-1:0]         s1_level_q;
  lae_pkg::stage_e                    s1_stage_q;
  logic signed [lae_pkg::LevelW:0]    s1_level_ext;

  logic                               s2_valid_q;
  logic signed [lae_pkg::ProdW-1:0]   s2_prod_q;
  logic [lae_pkg::LevelW-1:0]         s2_level_q;
  lae_pkg::stage_e                    s2_stage_q;
  logic signed [lae_pkg::ShiftW-1:0]  shifted;
  logic [lae_pkg::SampleW-1:0]        sat;

  // result-queue credit: words already in flight count against free slots
  assign busy = res_cnt_i + lae_pkg::CntW'(s1_valid_q) + lae_pkg::CntW'(s2_valid_q);
  assign issue     = cmd_valid_i && (busy < lae_pkg::CntW'(lae_pkg::ResQDepth));
  assign cmd_pop_o = issue;
  assign is_sample = (cmd_i.kind == lae_pkg::CMD_SAMPLE);

  assign sus     = (cfg_i.sustain_level > lae_pkg::One) ? lae_pkg::One : cfg_i.sustain_level;
  assign att_sum = {2'b00, level_q} + {2'b00, cfg_i.attack_step};
  assign dec_dif = {2'b00, level_q} - {2'b00, cfg_i.decay_step};
  assign rel_dif = {2'b00, level_q} - {2'b00, cfg_i.release_step};

  always_comb begin
    stage_d = stage_q;
    level_d = level_q;
    if (issue) begin
      case (cmd_i.kind)
        lae_pkg::CMD_ATTACK:  stage_d = lae_pkg::ST_ATTACK;
        lae_pkg::CMD_RELEASE: stage_d = lae_pkg::ST_RELEASE;
        lae_pkg::CMD_SAMPLE: begin
          case (stage_q)
            lae_pkg::ST_ATTACK: begin
              if (att_sum >= {2'b00, lae_pkg::One}) begin
                level_d = lae_pkg::One;
                stage_d = lae_pkg::ST_DECAY;
              end else begin
                level_d = att_sum[lae_pkg::LevelW-1:0];
              end
            end
            lae_pkg::ST_DECAY: begin
              if ($signed(dec_dif) <= $signed({2'b00, sus})) begin
                level_d = sus;
                stage_d = lae_pkg::ST_SUSTAIN;
              end else begin
                level_d = dec_dif[lae_pkg::LevelW-1:0];
              end
            end
            lae_pkg::ST_SUSTAIN: level_d = sus;
            lae_pkg::ST_RELEASE: begin
              if (rel_dif[AccW-1] || (rel_dif == '0)) begin
                level_d = '0;
                stage_d = lae_pkg::ST_IDLE;
              end else begin
                level_d = rel_dif[lae_pkg::LevelW-1:0];
              end
            end
            default: begin
              level_d = '0;
              stage_d = lae_pkg::ST_IDLE;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q    <= lae_pkg::ST_IDLE;
      level_q    <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      stage_q    <= stage_d;
      level_q    <= level_d;
      s1_valid_q <= issue && is_sample;
      s2_valid_q <= s1_valid_q;
    end
  end

  assign s1_level_ext = $signed({1'b0, s1_level_q});

  always_ff @(posedge clk_i) begin
    if (issue && is_sample) begin
      s1_sample_q <= $signed(cmd_i.sample);
      s1_level_q  <= level_d;
      s1_stage_q  <= stage_d;
    end
    if (s1_valid_q) begin
      s2_prod_q  <= s1_sample_q * s1_level_ext;
      s2_level_q <= s1_level_q;
      s2_stage_q <= s1_stage_q;
    end
  end

  // arithmetic shift is floor; clip when the top bits disagree
  assign shifted = s2_prod_q[lae_pkg::ProdW-1:lae_pkg::FracBits];

  always_comb begin
    if ((&shifted[lae_pkg::ShiftW-1:lae_pkg::SampleW-1]) ||
        !(|shifted[lae_pkg::ShiftW-1:lae_pkg::SampleW-1])) begin
      sat = shifted[lae_pkg::SampleW-1:0];
    end else if (shifted[lae_pkg::ShiftW-1]) begin
      sat = {1'b1, {(lae_pkg::SampleW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(lae_pkg::SampleW-1){1'b1}}};
    end
  end

  assign res_push_o       = s2_valid_q;
  assign res_o.out_sample = sat;
  assign res_o.level      = s2_level_q;
  assign res_o.stage      = s2_stage_q;
  assign res_o.active     = (s2_stage_q != lae_pkg::ST_IDLE);
  assign res_o.finished   = (s2_stage_q == lae_pkg::ST_IDLE) &&
                            (s2_level_q < lae_pkg::FinishLimit);

  `LAE_ASSERT_IMP(a_level_max, 1'b1, level_q <= lae_pkg::One, "level above one")
  `LAE_ASSERT_NXT(a_note_on, issue && (cmd_i.kind == lae_pkg::CMD_ATTACK),
                  stage_q == lae_pkg::ST_ATTACK, "note-on did not enter attack")

endmodule

`default_nettype wire

@@ hdl/lae_resq.sv @@
`default_nettype none

module lae_resq (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       push_i,
  input  lae_pkg::res_t             res_i,
  output logic [lae_pkg::CntW-1:0]  cnt_o,
  output logic                      empty_o,
  output lae_pkg::res_t             res_o,
  input  wire                       pop_i
);

  `include "linear_adsr_envelope_macros.svh"

  lae_pkg::res_t                 mem_q [lae_pkg::ResQDepth];
  logic [lae_pkg::ResPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [lae_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic                          deq;

  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;
  assign res_o   = mem_q[rd_ptr_q];
  assign deq     = pop_i && !empty_o;

  always_comb begin
    case ({push_i, deq})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (deq)    rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= res_i;
  end

  `LAE_ASSERT_IMP(a_no_overflow, push_i,
                  (cnt_q < lae_pkg::CntW'(lae_pkg::ResQDepth)) || deq,
                  "result word pushed into a full queue")

endmodule

`default_nettype wire

@@ hdl/linear_adsr_envelope.sv @@
// Linear ADSR envelope. Accepts one word per cycle unless full; one result word
// per sample. Path of a sample: command queue, level update, multiply, result
// queue; words leave the command queue only while the result queue has credit.
// Throughput: one word per cycle unless stalled, set by the level update loop.
// Reset (rst_ni low, async): stage idle, level 0, registers to defaults,
// both queues empty. No clearing pass.
`default_nettype none

module linear_adsr_envelope (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          push,
  output logic                         full,
  input  wire  [1:0]                   operation_i,
  input  wire  [lae_pkg::SampleW-1:0]  in_sample_i,
  output logic                         empty,
  input  wire                          pop,
  output logic [lae_pkg::SampleW-1:0]  out_sample_o,
  output logic [lae_pkg::LevelW-1:0]   level_o,
  output logic [2:0]                   stage_now_o,
  output logic                         active_o,
  output logic                         finished_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [1:0]                   cfg_index_i,
  input  wire  [lae_pkg::LevelW-1:0]   cfg_data_i
);

  lae_pkg::cfg_t             cfg_q;
  logic                      cmd_valid, cmd_pop, res_push;
  lae_pkg::cmd_t             cmd;
  lae_pkg::res_t             res_new, res_head;
  logic [lae_pkg::CntW-1:0]  res_cnt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_step   <= lae_pkg::AttackStepRst;
      cfg_q.decay_step    <= lae_pkg::DecayStepRst;
      cfg_q.sustain_level <= lae_pkg::SustainLevelRst;
      cfg_q.release_step  <= lae_pkg::ReleaseStepRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (lae_pkg::cfg_idx_e'(cfg_index_i))
        lae_pkg::CFG_ATTACK:  cfg_q.attack_step   <= cfg_data_i;
        lae_pkg::CFG_DECAY:   cfg_q.decay_step    <= cfg_data_i;
        lae_pkg::CFG_SUSTAIN: cfg_q.sustain_level <= cfg_data_i;
        lae_pkg::CFG_RELEASE: cfg_q.release_step  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lae_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .operation_i (operation_i),
    .in_sample_i (in_sample_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  lae_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_cnt_i   (res_cnt),
    .res_push_o  (res_push),
    .res_o       (res_new)
  );

  lae_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_new),
    .cnt_o   (res_cnt),
    .empty_o (empty),
    .res_o   (res_head),
    .pop_i   (pop)
  );

  assign out_sample_o = res_head.out_sample;
  assign level_o      = res_head.level;
  assign stage_now_o  = 3'(res_head.stage);
  assign active_o     = res_head.active;
  assign finished_o   = res_head.finished;

endmodule

`default_nettype wire
